[rtl/core/raster_coverage_stats_defines.svh]
// Assertion macros for the coverage statistics RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef RASTER_COVERAGE_STATS_DEFINES_SVH
`define RASTER_COVERAGE_STATS_DEFINES_SVH

`ifndef SYNTHESIS
`define RCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");
`else
`define RCS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/rcs_pkg.sv]
// Shared constants, types and saturating arithmetic for the coverage statistics block.
// No dependencies; imported by every module of the block.
package rcs_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HEIGHT     = 4096;
   localparam int COUNT_BITS     = 16;
   localparam int FRAG_BITS      = 16;
   localparam int REG_BITS       = 13;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int HEIGHT_BITS    = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_BITS       = 48;
   localparam int TALLY_BITS     = 25;
   localparam int CSR_INDEX_BITS = 4;
   localparam int RESET_WIDTH    = 512;
   localparam int RESET_HEIGHT   = 512;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
   } frame_geom_type;

   // One pixel as classified by the front end.
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [COL_BITS-1:0]   col;
      logic                  row_ge1;
      logic                  row_ge2;
      logic                  row_is1;
      logic                  col_ge1;
      logic                  col_ge2;
      logic                  last_col;
      logic                  last_pixel;
   } pixel_item_type;

   function automatic logic [SUM_BITS-1:0] sat_add_sum(input logic [SUM_BITS-1:0] a,
                                                       input logic [COUNT_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + (SUM_BITS + 1)'(b);
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   function automatic logic [TALLY_BITS-1:0] sat_add_tally(input logic [TALLY_BITS-1:0] a,
                                                           input logic [1:0] b);
      logic [TALLY_BITS:0] s;
      s = {1'b0, a} + (TALLY_BITS + 1)'(b);
      return s[TALLY_BITS] ? {TALLY_BITS{1'b1}} : s[TALLY_BITS-1:0];
   endfunction

endpackage

[rtl/core/raster_coverage_stats.sv]
// Frame coverage statistics over a raster stream of per-pixel fragment counts.
// Takes one pixel per cycle while the queue has room; the queue fills while a frame is closed: at the end
// of each frame the back end flushes the line store across the frame width, drains its
// pipeline and hands over a registered result that is held until the receiver takes it.
// Reset (synchronous): position and statistics cleared, width and height set to 512;
// the line store is not cleared, and no entry is used before it is written in the frame.
module raster_coverage_stats import rcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FRAG_BITS-1:0]      req_frag_count,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SUM_BITS-1:0]       rsp_total_fragments,
   output logic [TALLY_BITS-1:0]     rsp_covered_pixels,
   output logic [TALLY_BITS-1:0]     rsp_overwritten_pixels,
   output logic [SUM_BITS-1:0]       rsp_lost_fragments,
   output logic [TALLY_BITS-1:0]     rsp_boundary_pixels,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wdata
);

   logic           q_full, q_push, q_pop, q_valid, frame_clear;
   pixel_item_type q_item, q_head;
   frame_geom_type geom;

   rcs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frag_count (req_frag_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item),
      .geom           (geom),
      .frame_clear    (frame_clear)
   );

   rcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   rcs_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .geom                   (geom),
      .frame_clear            (frame_clear),
      .q_valid                (q_valid),
      .q_head                 (q_head),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_total_fragments    (rsp_total_fragments),
      .rsp_covered_pixels     (rsp_covered_pixels),
      .rsp_overwritten_pixels (rsp_overwritten_pixels),
      .rsp_lost_fragments     (rsp_lost_fragments),
      .rsp_boundary_pixels    (rsp_boundary_pixels)
   );

endmodule

[rtl/core/rcs_front.sv]
// Front end: frame registers, raster position tracking and pixel classification.
// Depends on rcs_pkg; feeds rcs_queue.
module rcs_front import rcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FRAG_BITS-1:0]      req_frag_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wdata,
   input  logic                      q_full,
   output logic                      q_push,
   output pixel_item_type            q_item,
   output frame_geom_type            geom,
   output logic                      frame_clear
);

   logic [REG_BITS-1:0] frame_width_ff, frame_width_in;
   logic [REG_BITS-1:0] frame_height_ff, frame_height_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                wr_width, wr_height, accept, last_col, last_row;

   assign csr_ready   = 1'b1;
   assign wr_width    = csr_valid && (csr_index == CSR_FRAME_WIDTH);
   assign wr_height   = csr_valid && (csr_index == CSR_FRAME_HEIGHT);
   assign frame_clear = wr_width || wr_height;

   // Out-of-range sizes are clamped: zero acts as one, oversize as the maximum.
   always_comb begin
      priority if (frame_width_ff == '0) begin
         geom.width = WIDTH_BITS'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         geom.width = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         geom.width = WIDTH_BITS'(frame_width_ff);
      end
      priority if (frame_height_ff == '0) begin
         geom.height = HEIGHT_BITS'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         geom.height = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         geom.height = HEIGHT_BITS'(frame_height_ff);
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   assign last_col = (WIDTH_BITS'(col_ff) + WIDTH_BITS'(1)) == geom.width;
   assign last_row = (HEIGHT_BITS'(row_ff) + HEIGHT_BITS'(1)) == geom.height;

   always_comb begin
      q_item.count      = req_frag_count[COUNT_BITS-1:0];
      q_item.col        = col_ff;
      q_item.row_ge1    = row_ff != '0;
      q_item.row_ge2    = row_ff[ROW_BITS-1:1] != '0;
      q_item.row_is1    = row_ff == ROW_BITS'(1);
      q_item.col_ge1    = col_ff != '0;
      q_item.col_ge2    = col_ff[COL_BITS-1:1] != '0;
      q_item.last_col   = last_col;
      q_item.last_pixel = last_col && last_row;
   end

   always_comb begin
      frame_width_in  = wr_width ? csr_wdata : frame_width_ff;
      frame_height_in = wr_height ? csr_wdata : frame_height_ff;
      col_in = col_ff;
      row_in = row_ff;
      priority if (frame_clear) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= REG_BITS'(RESET_WIDTH);
         frame_height_ff <= REG_BITS'(RESET_HEIGHT);
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

endmodule

[rtl/core/rcs_queue.sv]
// Short register queue of classified pixels between the front and back ends.
// Depends on rcs_pkg.
module rcs_queue import rcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pixel_item_type push_item,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output pixel_item_type head
);

   pixel_item_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     fill_ff, fill_in;

   assign full      = fill_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/core/rcs_back.sv]
// Back end: line store, 3x3 window settling, statistics, end-of-frame flush and result.
// Depends on rcs_pkg and raster_coverage_stats_defines.svh; fed by rcs_queue.
`include "raster_coverage_stats_defines.svh"

module rcs_back import rcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  frame_geom_type        geom,
   input  logic                  frame_clear,
   input  logic                  q_valid,
   input  pixel_item_type        q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SUM_BITS-1:0]   rsp_total_fragments,
   output logic [TALLY_BITS-1:0] rsp_covered_pixels,
   output logic [TALLY_BITS-1:0] rsp_overwritten_pixels,
   output logic [SUM_BITS-1:0]   rsp_lost_fragments,
   output logic [TALLY_BITS-1:0] rsp_boundary_pixels
);

   // Vertical summary bits of one column.
   localparam logic [2:0] VS_CENTER  = 3'b001;
   localparam logic [2:0] VS_ZERO    = 3'b010;
   localparam logic [2:0] VS_NONZERO = 3'b100;

   typedef enum logic [3:0] {
      ST_RUN    = 4'b0001,
      ST_FLUSH  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   typedef struct packed {
      logic                  is_pixel;
      logic [COUNT_BITS-1:0] count;
      logic [COL_BITS-1:0]   col;
      logic                  settle_en;
      logic                  has_above;
      logic                  has_below;
      logic                  edge_row;
      logic                  col_ge1;
      logic                  col_ge2;
      logic                  last_col;
      logic                  last_pixel;
   } work_type;

   function automatic logic [2:0] vert_summary(input logic has_above, input logic above,
                                               input logic center, input logic has_below,
                                               input logic below);
      logic [2:0] f;
      f = center ? (VS_CENTER | VS_NONZERO) : VS_ZERO;
      if (has_above) f = f | (above ? VS_NONZERO : VS_ZERO);
      if (has_below) f = f | (below ? VS_NONZERO : VS_ZERO);
      return f;
   endfunction

   state_type             state_ff, state_in;
   logic [COL_BITS-1:0]   fl_col_ff, fl_col_in;
   logic                  wk_valid_ff, wk_valid_in;
   work_type              wk_ff, wk_in;
   logic [1:0]            prev_mem [MAX_WIDTH];
   logic [1:0]            rd_data_ff;
   logic                  mem_rd_en;
   logic [COL_BITS-1:0]   mem_rd_addr;
   logic                  mem_wr_en;
   logic [1:0]            mem_wr_data;
   logic                  byp_valid_ff, byp_valid_in;
   logic [1:0]            byp_data_ff;
   logic [2:0]            win1_ff, win2_ff;
   logic [1:0]            p_flags;
   logic                  below;
   logic [2:0]            vsum, acc_left, acc_right;
   logic                  left_en, right_en, left_cov, left_bnd, right_cov, right_bnd;
   logic [1:0]            cov_inc, bnd_inc;
   logic                  fl_last, slot_free, clear_stats;
   work_type              pix_work, fl_work;

   logic [SUM_BITS-1:0]   fragment_sum_ff, fragment_sum_in;
   logic [SUM_BITS-1:0]   lost_sum_ff, lost_sum_in;
   logic [TALLY_BITS-1:0] covered_ff, covered_in;
   logic [TALLY_BITS-1:0] overwritten_ff, overwritten_in;
   logic [TALLY_BITS-1:0] boundary_ff, boundary_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]   rsp_total_fragments_ff;
   logic [TALLY_BITS-1:0] rsp_covered_pixels_ff;
   logic [TALLY_BITS-1:0] rsp_overwritten_pixels_ff;
   logic [SUM_BITS-1:0]   rsp_lost_fragments_ff;
   logic [TALLY_BITS-1:0] rsp_boundary_pixels_ff;

   assign fl_last   = (WIDTH_BITS'(fl_col_ff) + WIDTH_BITS'(1)) == geom.width;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // The flush may not start reading the line store while the last pixel is
   // still in the work stage, so no pixel is taken behind it.
   assign q_pop = (state_ff == ST_RUN) && q_valid && !(wk_valid_ff && wk_ff.last_pixel);

   always_comb begin
      pix_work.is_pixel   = 1'b1;
      pix_work.count      = q_head.count;
      pix_work.col        = q_head.col;
      pix_work.settle_en  = q_head.row_ge1;
      pix_work.has_above  = q_head.row_ge2;
      pix_work.has_below  = 1'b1;
      pix_work.edge_row   = q_head.row_is1;
      pix_work.col_ge1    = q_head.col_ge1;
      pix_work.col_ge2    = q_head.col_ge2;
      pix_work.last_col   = q_head.last_col;
      pix_work.last_pixel = q_head.last_pixel;

      // The last row has no row below and always lies on the frame edge.
      fl_work.is_pixel   = 1'b0;
      fl_work.count      = '0;
      fl_work.col        = fl_col_ff;
      fl_work.settle_en  = 1'b1;
      fl_work.has_above  = geom.height != HEIGHT_BITS'(1);
      fl_work.has_below  = 1'b0;
      fl_work.edge_row   = 1'b1;
      fl_work.col_ge1    = fl_col_ff != '0;
      fl_work.col_ge2    = fl_col_ff[COL_BITS-1:1] != '0;
      fl_work.last_col   = fl_last;
      fl_work.last_pixel = 1'b0;
   end

   always_comb begin
      state_in    = state_ff;
      fl_col_in   = fl_col_ff;
      wk_valid_in = 1'b0;
      wk_in       = pix_work;
      mem_rd_en   = 1'b0;
      mem_rd_addr = q_head.col;
      unique case (state_ff)
         ST_RUN: begin
            wk_valid_in = q_pop;
            mem_rd_en   = q_pop;
            if (wk_valid_ff && wk_ff.last_pixel) begin
               state_in  = ST_FLUSH;
               fl_col_in = '0;
            end
         end
         ST_FLUSH: begin
            wk_valid_in = 1'b1;
            wk_in       = fl_work;
            mem_rd_en   = 1'b1;
            mem_rd_addr = fl_col_ff;
            if (fl_last) begin
               state_in = ST_DRAIN;
            end else begin
               fl_col_in = fl_col_ff + COL_BITS'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // With a one-pixel row the next pixel reads the column being written back.
   assign p_flags      = byp_valid_ff ? byp_data_ff : rd_data_ff;
   assign below        = wk_ff.count != '0;
   assign vsum         = vert_summary(wk_ff.has_above, p_flags[1], p_flags[0],
                                      wk_ff.has_below, below);
   assign mem_wr_en    = wk_valid_ff && wk_ff.is_pixel;
   assign mem_wr_data  = {wk_ff.settle_en ? p_flags[0] : 1'b0, below};
   assign byp_valid_in = q_pop && mem_wr_en && (q_head.col == wk_ff.col);

   // The column to the left is settled now that its right neighbor is known;
   // at the end of a row the last column is settled as well.
   always_comb begin
      left_en   = wk_valid_ff && wk_ff.settle_en && wk_ff.col_ge1;
      right_en  = wk_valid_ff && wk_ff.settle_en && wk_ff.last_col;
      acc_left  = win1_ff | (wk_ff.col_ge2 ? win2_ff : 3'b000) | vsum;
      acc_right = vsum | (wk_ff.col_ge1 ? win1_ff : 3'b000);
      left_cov  = left_en && (win1_ff[0] || ((acc_left & VS_NONZERO) != '0));
      left_bnd  = left_en && win1_ff[0] &&
                  (wk_ff.edge_row || !wk_ff.col_ge2 || ((acc_left & VS_ZERO) != '0));
      right_cov = right_en && (vsum[0] || ((acc_right & VS_NONZERO) != '0));
      right_bnd = right_en && vsum[0];
      cov_inc   = {1'b0, left_cov} + {1'b0, right_cov};
      bnd_inc   = {1'b0, left_bnd} + {1'b0, right_bnd};
   end

   assign clear_stats = frame_clear || ((state_ff == ST_RESULT) && slot_free);

   always_comb begin
      fragment_sum_in = fragment_sum_ff;
      lost_sum_in     = lost_sum_ff;
      covered_in      = covered_ff;
      overwritten_in  = overwritten_ff;
      boundary_in     = boundary_ff;
      priority if (clear_stats) begin
         fragment_sum_in = '0;
         lost_sum_in     = '0;
         covered_in      = '0;
         overwritten_in  = '0;
         boundary_in     = '0;
      end else if (wk_valid_ff) begin
         if (wk_ff.is_pixel) begin
            fragment_sum_in = sat_add_sum(fragment_sum_ff, wk_ff.count);
            if (wk_ff.count > COUNT_BITS'(1)) begin
               overwritten_in = sat_add_tally(overwritten_ff, 2'd1);
               lost_sum_in    = sat_add_sum(lost_sum_ff, wk_ff.count - COUNT_BITS'(1));
            end
         end
         covered_in  = sat_add_tally(covered_ff, cov_inc);
         boundary_in = sat_add_tally(boundary_ff, bnd_inc);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if ((state_ff == ST_RESULT) && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         prev_mem[wk_ff.col] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= prev_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wk_valid_in) begin
         wk_ff <= wk_in;
      end
      byp_data_ff <= mem_wr_data;
      if (wk_valid_ff) begin
         win2_ff <= win1_ff;
         win1_ff <= vsum;
      end
      if ((state_ff == ST_RESULT) && slot_free) begin
         rsp_total_fragments_ff    <= fragment_sum_ff;
         rsp_covered_pixels_ff     <= covered_ff;
         rsp_overwritten_pixels_ff <= overwritten_ff;
         rsp_lost_fragments_ff     <= lost_sum_ff;
         rsp_boundary_pixels_ff    <= boundary_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         fl_col_ff       <= '0;
         wk_valid_ff     <= 1'b0;
         byp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         fragment_sum_ff <= '0;
         lost_sum_ff     <= '0;
         covered_ff      <= '0;
         overwritten_ff  <= '0;
         boundary_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         fl_col_ff       <= fl_col_in;
         wk_valid_ff     <= wk_valid_in;
         byp_valid_ff    <= byp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         fragment_sum_ff <= fragment_sum_in;
         lost_sum_ff     <= lost_sum_in;
         covered_ff      <= covered_in;
         overwritten_ff  <= overwritten_in;
         boundary_ff     <= boundary_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_total_fragments    = rsp_total_fragments_ff;
   assign rsp_covered_pixels     = rsp_covered_pixels_ff;
   assign rsp_overwritten_pixels = rsp_overwritten_pixels_ff;
   assign rsp_lost_fragments     = rsp_lost_fragments_ff;
   assign rsp_boundary_pixels    = rsp_boundary_pixels_ff;

   `RCS_ASSERT_IMPL(a_pop_only_in_run, clock, reset, q_pop, state_ff == ST_RUN)
   `RCS_ASSERT_NEXT(a_last_pixel_flushes, clock, reset, wk_valid_ff && wk_ff.is_pixel && wk_ff.last_pixel, state_ff == ST_FLUSH)
   `RCS_ASSERT_NEXT(a_result_delivered, clock, reset, (state_ff == ST_RESULT) && slot_free, rsp_valid_ff && (state_ff == ST_RUN))

endmodule

[dv/raster_coverage_stats_tb.sv]
// Self-checking testbench for raster_coverage_stats: frames of fragment counts go in,
// per-frame statistics are predicted by a scoreboard class and checked as they transfer.
// Depends on rcs_pkg and the raster_coverage_stats RTL only.
`timescale 1ns / 100ps

module raster_coverage_stats_tb;
   import rcs_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 8;
   localparam int          RANDOM_ITEMS = 720;
   localparam int          CLAMP_PIXELS = 32;
   localparam int          LONG_HOLD    = 400;
   localparam int          DRAIN_GUARD  = 100000;
   localparam longint      TIMEOUT_NS   = 64'd9_600_000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_TOP = '1;

   // Per-column flag bits of the vertical summary.
   localparam bit [2:0] FLAG_CENTER  = 3'b001;
   localparam bit [2:0] FLAG_ZERO    = 3'b010;
   localparam bit [2:0] FLAG_NONZERO = 3'b100;

   typedef struct packed {
      logic [SUM_BITS-1:0]   total_fragments;
      logic [TALLY_BITS-1:0] covered_pixels;
      logic [TALLY_BITS-1:0] overwritten_pixels;
      logic [SUM_BITS-1:0]   lost_fragments;
      logic [TALLY_BITS-1:0] boundary_pixels;
   } frame_stats_type;

   class frame_stats_board_type;
      logic [REG_BITS-1:0]   width_reg;
      logic [REG_BITS-1:0]   height_reg;
      bit [2:0]              above_flags [MAX_WIDTH];
      bit [2:0]              pending_flags [MAX_WIDTH];
      int unsigned           row;
      int unsigned           col;
      logic [SUM_BITS-1:0]   frag_sum;
      logic [SUM_BITS-1:0]   lost_sum;
      logic [TALLY_BITS-1:0] covered;
      logic [TALLY_BITS-1:0] overwritten;
      logic [TALLY_BITS-1:0] boundary;
      frame_stats_type       expected_stats [$];
      int unsigned           errors;

      function new();
         width_reg  = REG_BITS'(RESET_WIDTH);
         height_reg = REG_BITS'(RESET_HEIGHT);
         errors     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         row         = 0;
         col         = 0;
         frag_sum    = '0;
         lost_sum    = '0;
         covered     = '0;
         overwritten = '0;
         boundary    = '0;
      endfunction

      function int unsigned active_width();
         if (width_reg == 0) return 1;
         return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      endfunction

      function int unsigned active_height();
         if (height_reg == 0) return 1;
         return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      endfunction

      function int unsigned pending();
         return expected_stats.size();
      endfunction

      function logic [SUM_BITS-1:0] sum_saturate(logic [SUM_BITS-1:0] acc,
                                                 logic [SUM_BITS-1:0] inc);
         logic [SUM_BITS:0] wide;
         wide = {1'b0, acc} + {1'b0, inc};
         return wide[SUM_BITS] ? {SUM_BITS{1'b1}} : wide[SUM_BITS-1:0];
      endfunction

      function logic [TALLY_BITS-1:0] tally_bump(logic [TALLY_BITS-1:0] t);
         return (t == {TALLY_BITS{1'b1}}) ? t : t + 1'b1;
      endfunction

      function bit [2:0] column_summary(bit has_above, bit above, bit center,
                                        bit has_below, bit below);
         bit [2:0] f;
         f = center ? (FLAG_CENTER | FLAG_NONZERO) : FLAG_ZERO;
         if (has_above) f |= above ? FLAG_NONZERO : FLAG_ZERO;
         if (has_below) f |= below ? FLAG_NONZERO : FLAG_ZERO;
         return f;
      endfunction

      // Combines the column summaries left, centre and right into the 3x3 window.
      function void settle_pixel(int unsigned r, int unsigned c, int unsigned w,
                                 int unsigned h);
         bit [2:0] acc;
         bit       center;
         bit       on_edge;
         acc    = pending_flags[c];
         center = acc[0];
         if (c > 0) acc |= pending_flags[c - 1];
         if (c + 1 < w) acc |= pending_flags[c + 1];
         if (center) begin
            on_edge = (r == 0) || (r + 1 == h) || (c == 0) || (c + 1 == w);
            covered = tally_bump(covered);
            if (on_edge || (acc & FLAG_ZERO) != 0) boundary = tally_bump(boundary);
         end else if ((acc & FLAG_NONZERO) != 0) begin
            covered = tally_bump(covered);
         end
      endfunction

      function void note_csr(logic [CSR_INDEX_BITS-1:0] index, logic [REG_BITS-1:0] data);
         if (index == CSR_FRAME_WIDTH) width_reg = data;
         else if (index == CSR_FRAME_HEIGHT) height_reg = data;
         else return;
         clear_frame();
      endfunction

      function void take_pixel(logic [FRAG_BITS-1:0] frag);
         int unsigned          w;
         int unsigned          h;
         int unsigned          r;
         int unsigned          c;
         logic [COUNT_BITS-1:0] n;
         bit                   nz;
         bit [2:0]             p;
         frame_stats_type      stats;
         w  = active_width();
         h  = active_height();
         r  = row;
         c  = col;
         n  = frag[COUNT_BITS-1:0];
         nz = (n != 0);
         if (c >= w) c = w - 1;
         frag_sum = sum_saturate(frag_sum, SUM_BITS'(n));
         if (n > 1) begin
            overwritten = tally_bump(overwritten);
            lost_sum    = sum_saturate(lost_sum, SUM_BITS'(n) - 1'b1);
         end
         p = above_flags[c];
         if (r >= 1) begin
            pending_flags[c] = column_summary(r >= 2, p[1], p[0], 1'b1, nz);
            if (c >= 1) settle_pixel(r - 1, c - 1, w, h);
            if (c + 1 == w) settle_pixel(r - 1, c, w, h);
            above_flags[c] = {1'b0, p[0], nz};
         end else begin
            above_flags[c] = {2'b00, nz};
         end
         c++;
         if (c < w) begin
            col = c;
            return;
         end
         col = 0;
         r++;
         if (r < h) begin
            row = r;
            return;
         end
         // The last row has no row below; settle it in a sweep.
         for (int unsigned k = 0; k < w; k++) begin
            p = above_flags[k];
            pending_flags[k] = column_summary(h >= 2, p[1], p[0], 1'b0, 1'b0);
         end
         for (int unsigned k = 0; k < w; k++) settle_pixel(h - 1, k, w, h);
         stats.total_fragments    = frag_sum;
         stats.covered_pixels     = covered;
         stats.overwritten_pixels = overwritten;
         stats.lost_fragments     = lost_sum;
         stats.boundary_pixels    = boundary;
         expected_stats.insert(expected_stats.size(), stats);
         clear_frame();
      endfunction

      function void compare_field(string name, logic [SUM_BITS-1:0] exp_val,
                                  logic [SUM_BITS-1:0] got_val);
         if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_stats(frame_stats_type got);
         frame_stats_type exp_stats;
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual total %0d",
                     $time, got.total_fragments);
            errors++;
            return;
         end
         exp_stats = expected_stats.pop_front();
         compare_field("total_fragments", exp_stats.total_fragments, got.total_fragments);
         compare_field("covered_pixels", SUM_BITS'(exp_stats.covered_pixels),
                       SUM_BITS'(got.covered_pixels));
         compare_field("overwritten_pixels", SUM_BITS'(exp_stats.overwritten_pixels),
                       SUM_BITS'(got.overwritten_pixels));
         compare_field("lost_fragments", exp_stats.lost_fragments, got.lost_fragments);
         compare_field("boundary_pixels", SUM_BITS'(exp_stats.boundary_pixels),
                       SUM_BITS'(got.boundary_pixels));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FRAG_BITS-1:0]      req_frag_count = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SUM_BITS-1:0]       rsp_total_fragments;
   logic [TALLY_BITS-1:0]     rsp_covered_pixels;
   logic [TALLY_BITS-1:0]     rsp_overwritten_pixels;
   logic [SUM_BITS-1:0]       rsp_lost_fragments;
   logic [TALLY_BITS-1:0]     rsp_boundary_pixels;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0]       csr_wdata = '0;

   frame_stats_board_type board = new();

   int unsigned items_sent = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_ticket = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   raster_coverage_stats dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_frag_count         (req_frag_count),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_total_fragments    (rsp_total_fragments),
      .rsp_covered_pixels     (rsp_covered_pixels),
      .rsp_overwritten_pixels (rsp_overwritten_pixels),
      .rsp_lost_fragments     (rsp_lost_fragments),
      .rsp_boundary_pixels    (rsp_boundary_pixels),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver back-pressure; a long hold is counted out here once requested.
   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : sample_rsp
      frame_stats_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.total_fragments    = rsp_total_fragments;
         got.covered_pixels     = rsp_covered_pixels;
         got.overwritten_pixels = rsp_overwritten_pixels;
         got.lost_fragments     = rsp_lost_fragments;
         got.boundary_pixels    = rsp_boundary_pixels;
         board.check_stats(got);
      end
   end

   function automatic logic [FRAG_BITS-1:0] random_count(int unsigned zero_pct);
      int unsigned pick;
      if ($urandom_range(99) < zero_pct) return '0;
      pick = $urandom_range(9);
      if (pick < 4) return 1;
      if (pick < 7) return FRAG_BITS'($urandom_range(2, 8));
      if (pick < 9) return FRAG_BITS'($urandom);
      return '1;
   endfunction

   function automatic logic [REG_BITS-1:0] pick_dimension(int unsigned top);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6) return '0;
      if (pick < 12) return 1;
      if (pick < 20) return 2;
      return REG_BITS'($urandom_range(3, top));
   endfunction

   // All driving tasks start and end at a falling edge. Valid stays high between
   // back-to-back pixels and drops only when the sender idles, pauses or writes a register.
   task automatic send_pixel(input logic [FRAG_BITS-1:0] frag);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_frag_count = frag;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_pixel(frag);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [REG_BITS-1:0] data);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.note_csr(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits for every expected result, then lets the frame flush latency pass.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (board.active_width() + 16) @(negedge clock);
   endtask

   task automatic set_geometry(input logic [REG_BITS-1:0] w, input logic [REG_BITS-1:0] h);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic send_frame(input int unsigned zero_pct, input int unsigned pixels);
      for (int unsigned i = 0; i < pixels; i++) send_pixel(random_count(zero_pct));
   endtask

   task automatic random_segment();
      int unsigned frames;
      int unsigned pixels;
      int unsigned zero_pct;
      set_geometry(pick_dimension(10), pick_dimension(6));
      if ($urandom_range(4) == 0)
         write_csr(CSR_INDEX_BITS'($urandom_range(2, 15)), REG_BITS'($urandom));
      frames = $urandom_range(1, 4);
      pixels = board.active_width() * board.active_height();
      for (int unsigned f = 0; f < frames; f++) begin
         zero_pct = $urandom_range(95);
         // Now and then the last frame is cut short; the next register write restarts it.
         if (f + 1 == frames && pixels > 1 && $urandom_range(9) == 0)
            send_frame(zero_pct, $urandom_range(1, pixels - 1));
         else
            send_frame(zero_pct, pixels);
      end
   endtask

   task automatic run_phase(input int unsigned sender_idle, input int unsigned rx_stall);
      int unsigned phase_start;
      wait_idle();
      idle_pct    = sender_idle;
      stall_pct   = rx_stall;
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / 4) random_segment();
   endtask

   initial begin
      int unsigned guard;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single-pixel frames: an empty pixel and the largest count.
      set_geometry(1, 1);
      send_pixel('0);
      send_pixel('1);
      // A zero register acts as one.
      set_geometry(0, 0);
      send_pixel(1);
      // A lone nonzero pixel inside a zero frame: covers its window, is a boundary.
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? FRAG_BITS'(5) : '0);
      // A write to an unknown register mid-frame leaves the frame running.
      set_geometry(4, 2);
      send_pixel(2);
      send_pixel(0);
      send_pixel(7);
      wait_idle();
      write_csr(CSR_UNUSED_TOP, '1);
      send_pixel(1);
      send_pixel(0);
      send_pixel(3);
      send_pixel(1);
      send_pixel(0);
      // A partial frame is dropped by the next register write.
      send_pixel(9);
      send_pixel(0);
      // Oversized registers clamp to the largest frame dimension; the short runs of
      // pixels sent into those frames are dropped by the next register write.
      set_geometry('1, 1);
      send_frame(90, CLAMP_PIXELS);
      set_geometry(1, '1);
      send_frame(90, CLAMP_PIXELS);

      // The receiver holds off while small frames keep coming, so the block backs up.
      set_geometry(3, 2);
      hold_ticket++;
      for (int i = 0; i < 16; i++) send_frame(50, 6);

      run_phase(0, 0);
      run_phase(57, 0);
      run_phase(0, 57);
      run_phase(10, 10);

      req_valid = 1'b0;
      guard = 0;
      while (board.pending() != 0 && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      if (board.pending() != 0) begin
         $display("%0t: %0d results never arrived, expected %0d more, actual 0", $time,
                  board.pending(), board.pending());
         board.errors++;
      end
      repeat (board.active_width() + 16) @(negedge clock);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
